[hw/rtl/prrq_pkg.sv]
// Shared constants, codes and types for the priority round-robin ready queue.
// No dependencies; imported by every module of the block.
package prrq_pkg;

	localparam int LEVELS    = 32;
	localparam int MAX_TASKS = 32;

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int TASK_W = $clog2(MAX_TASKS);

	// Fixed field widths of the ports
	localparam int OP_W   = 2;
	localparam int ID_W   = 5;
	localparam int PRIO_W = 5;
	localparam int ST_W   = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_ALREADY   = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_READY = 2'd2;
	localparam logic [ST_W-1:0] ST_NONE      = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ID_W-1:0]   chosen_task;
		logic              chosen_valid;
		logic [PRIO_W-1:0] highest_ready;
		logic              any_ready;
	} result_t;

	// Requested levels above the top level clamp to the top level
	function automatic logic [LVL_W-1:0] sat_level(input logic [PRIO_W-1:0] req);
		if (32'(req) >= LEVELS) begin
			return LVL_W'(LEVELS - 1);
		end
		return LVL_W'(req);
	endfunction

endpackage

[hw/rtl/priority_round_robin_ready_queue.sv]
// Top level of the priority round-robin ready queue: input register, core
// update, result register. Depends on prrq_pkg and prrq_core.
//
//   channel | handshake          | payload
//   input   | in_valid/in_ready  | op, task_id, priority_req
//   output  | out_valid/out_ready| status, chosen_task, chosen_valid,
//           |                    | highest_ready, any_ready
//
// An item passes from the input register through the core update into
// the result register. One item per cycle sustained while out_ready holds;
// state updates complete in that single pass.
// Reset clears the ready set and level mask; links need no clearing.
// A stalled result holds in the result register while one more item waits
// in the input register; in_ready drops only when both are full.
module priority_round_robin_ready_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [prrq_pkg::OP_W-1:0]   op,
	input  logic [prrq_pkg::ID_W-1:0]   task_id,
	input  logic [prrq_pkg::PRIO_W-1:0] priority_req,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [prrq_pkg::ST_W-1:0]   status,
	output logic [prrq_pkg::ID_W-1:0]   chosen_task,
	output logic                        chosen_valid,
	output logic [prrq_pkg::PRIO_W-1:0] highest_ready,
	output logic                        any_ready
);
	import prrq_pkg::*;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [ID_W-1:0]   id_s1;
	logic [PRIO_W-1:0] prio_s1;
	logic              out_free, fire, in_xfer;
	logic              out_valid_q;
	result_t           res, res_q;

	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= op;
			id_s1   <= task_id;
			prio_s1 <= priority_req;
		end
	end

	prrq_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.op           (op_s1),
		.task_id      (id_s1),
		.priority_req (prio_s1),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign chosen_task   = res_q.chosen_task;
	assign chosen_valid  = res_q.chosen_valid;
	assign highest_ready = res_q.highest_ready;
	assign any_ready     = res_q.any_ready;

endmodule

[hw/rtl/prrq_top_enc.sv]
// Priority encoder: highest set bit of the per-level ready mask.
// Depends on prrq_pkg.
module prrq_top_enc (
	input  logic [prrq_pkg::LEVELS-1:0] mask,
	output logic [prrq_pkg::LVL_W-1:0]  top,
	output logic                        any
);
	import prrq_pkg::*;

	always_comb begin
		top = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (mask[LVL_W'(i)]) begin
				top = LVL_W'(i);
			end
		end
		any = |mask;
	end

endmodule

[hw/rtl/prrq_core.sv]
// Ready set, rotation links, cursors and level mask, with the single-pass
// update for add, remove and switch. Depends on prrq_pkg and prrq_top_enc.
module prrq_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [prrq_pkg::OP_W-1:0]   op,
	input  logic [prrq_pkg::ID_W-1:0]   task_id,
	input  logic [prrq_pkg::PRIO_W-1:0] priority_req,
	output prrq_pkg::result_t           res
);
	import prrq_pkg::*;

	logic [MAX_TASKS-1:0] ready_q, ready_d;
	logic [LEVELS-1:0]    mask_q, mask_d;

	// No reset: an entry is only read once its task is ready or its level is live
	logic [LVL_W-1:0]  task_level_q [MAX_TASKS];
	logic [TASK_W-1:0] next_link_q  [MAX_TASKS];
	logic [TASK_W-1:0] prev_link_q  [MAX_TASKS];
	logic [TASK_W-1:0] cursor_q     [LEVELS];

	logic              id_ok, is_ready, lvl_live, rem_last;
	logic              add_do, rem_do, sw_do;
	logic [TASK_W-1:0] id_ix, rc_rd, nl_raddr, nl_rd, pl_raddr, pl_rd;
	logic [LVL_W-1:0]  lvl_sat, id_lvl, rc_raddr, cur_top, nxt_top;
	logic              cur_any, nxt_any;

	prrq_top_enc u_enc_cur (.mask(mask_q), .top(cur_top), .any(cur_any));
	prrq_top_enc u_enc_nxt (.mask(mask_d), .top(nxt_top), .any(nxt_any));

	always_comb begin
		id_ok    = 32'(task_id) < MAX_TASKS;
		id_ix    = TASK_W'(task_id);
		lvl_sat  = sat_level(priority_req);
		is_ready = id_ok && ready_q[id_ix];
		id_lvl   = task_level_q[id_ix];
		lvl_live = mask_q[lvl_sat];

		// One cursor read per op: add level, level of removed task, or top level
		unique case (op)
			OP_ADD:    rc_raddr = lvl_sat;
			OP_REMOVE: rc_raddr = id_lvl;
			default:   rc_raddr = cur_top;
		endcase
		rc_rd    = cursor_q[rc_raddr];
		nl_raddr = (op == OP_REMOVE) ? id_ix : rc_rd;
		nl_rd    = next_link_q[nl_raddr];
		pl_raddr = (op == OP_ADD) ? rc_rd : id_ix;
		pl_rd    = prev_link_q[pl_raddr];

		add_do   = fire && (op == OP_ADD) && id_ok && !ready_q[id_ix];
		rem_do   = fire && (op == OP_REMOVE) && is_ready;
		sw_do    = fire && (op == OP_SWITCH) && cur_any;
		rem_last = (nl_rd == id_ix);

		ready_d = ready_q;
		mask_d  = mask_q;
		if (add_do) begin
			ready_d[id_ix]  = 1'b1;
			mask_d[lvl_sat] = 1'b1;
		end
		if (rem_do) begin
			ready_d[id_ix] = 1'b0;
			if (rem_last) begin
				mask_d[id_lvl] = 1'b0;
			end
		end

		res = '0;
		unique case (op)
			OP_ADD: begin
				if (!id_ok) begin
					res.status = ST_NOT_READY;
				end else if (ready_q[id_ix]) begin
					res.status = ST_ALREADY;
				end else begin
					res.status = ST_OK;
				end
			end
			OP_REMOVE: res.status = is_ready ? ST_OK : ST_NOT_READY;
			OP_SWITCH: begin
				res.status = cur_any ? ST_OK : ST_NONE;
				if (cur_any) begin
					res.chosen_task  = ID_W'(rc_rd);
					res.chosen_valid = 1'b1;
				end
			end
			default: res.status = ST_OK;
		endcase
		res.highest_ready = nxt_any ? PRIO_W'(nxt_top) : '0;
		res.any_ready     = nxt_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
			mask_q  <= '0;
		end else if (fire) begin
			ready_q <= ready_d;
			mask_q  <= mask_d;
		end
	end

	// Link updates; every op writes distinct entries, so order does not matter
	always_ff @(posedge clk) begin
		if (add_do) begin
			task_level_q[id_ix] <= lvl_sat;
			if (lvl_live) begin
				// splice in before the cursor, i.e. at the end of the rotation
				next_link_q[pl_rd] <= id_ix;
				prev_link_q[id_ix] <= pl_rd;
				next_link_q[id_ix] <= rc_rd;
				prev_link_q[rc_rd] <= id_ix;
			end else begin
				next_link_q[id_ix] <= id_ix;
				prev_link_q[id_ix] <= id_ix;
				cursor_q[lvl_sat]  <= id_ix;
			end
		end
		if (rem_do && !rem_last) begin
			next_link_q[pl_rd] <= nl_rd;
			prev_link_q[nl_rd] <= pl_rd;
			if (rc_rd == id_ix) begin
				cursor_q[id_lvl] <= nl_rd;
			end
		end
		if (sw_do) begin
			cursor_q[cur_top] <= nl_rd;
		end
	end

	a_mask_tracks_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(|ready_q) == (|mask_q))
		else $error("level mask disagrees with ready set");

	a_chosen_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		sw_do |-> ready_q[rc_rd])
		else $error("switch picked a task that is not ready");

	a_add_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		add_do |=> ready_q[$past(id_ix)] && mask_q[$past(lvl_sat)])
		else $error("add did not mark task and level ready");

	a_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rem_do |=> !ready_q[$past(id_ix)])
		else $error("remove left task ready");

endmodule

[bench/tb_top.sv]
// Self-checking bench for priority_round_robin_ready_queue: directed and random
// add/remove/switch traffic against an in-bench scheduler model.
// Depends on prrq_pkg and the RTL of the block.
module tb_top;
	import prrq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op           = OP_SWITCH;
	logic [ID_W-1:0]     task_id      = '0;
	logic [PRIO_W-1:0]   priority_req = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [ST_W-1:0]     status;
	logic [ID_W-1:0]     chosen_task;
	logic                chosen_valid;
	logic [PRIO_W-1:0]   highest_ready;
	logic                any_ready;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_count      = 0;
	int idle_cycles    = 0;

	// scheduler model state
	logic [MAX_TASKS-1:0] task_ready = '0;
	logic [LVL_W-1:0]     task_lvl   [MAX_TASKS];
	logic [TASK_W-1:0]    succ       [MAX_TASKS];
	logic [TASK_W-1:0]    pred       [MAX_TASKS];
	logic [TASK_W-1:0]    turn       [LEVELS];
	logic [LEVELS-1:0]    lvl_mask   = '0;

	result_t pending_results[$];
	result_t want;

	always #1 clk = ~clk;

	priority_round_robin_ready_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.chosen_task  (chosen_task),
		.chosen_valid (chosen_valid),
		.highest_ready(highest_ready),
		.any_ready    (any_ready)
	);

	function automatic logic [LVL_W-1:0] top_level();
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (lvl_mask[LVL_W'(l)]) begin
				return LVL_W'(l);
			end
		end
		return '0;
	endfunction

	// Applies one operation to the model and returns the result it should give
	function automatic result_t sched_step(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pr);
		result_t r;
		logic [LVL_W-1:0] lv;
		logic [TASK_W-1:0] t, hd, tl, nx, pv;
		int tid;
		r = '0;
		r.status = ST_OK;
		tid = int'(id);
		t = TASK_W'(tid);
		case (o)
			OP_ADD: begin
				if (tid >= MAX_TASKS) begin
					r.status = ST_NOT_READY;
				end else if (task_ready[t]) begin
					r.status = ST_ALREADY;
				end else begin
					lv = (32'(pr) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(pr);
					if (lvl_mask[lv]) begin
						// join at the tail, just behind the task whose turn is next
						hd = turn[lv];
						tl = pred[hd];
						succ[tl] = t;
						pred[t] = tl;
						succ[t] = hd;
						pred[hd] = t;
					end else begin
						succ[t] = t;
						pred[t] = t;
						turn[lv] = t;
						lvl_mask[lv] = 1'b1;
					end
					task_lvl[t] = lv;
					task_ready[t] = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (tid >= MAX_TASKS || !task_ready[t]) begin
					r.status = ST_NOT_READY;
				end else begin
					lv = task_lvl[t];
					nx = succ[t];
					pv = pred[t];
					if (nx == t) begin
						lvl_mask[lv] = 1'b0;
					end else begin
						succ[pv] = nx;
						pred[nx] = pv;
						if (turn[lv] == t) begin
							turn[lv] = nx;
						end
					end
					task_ready[t] = 1'b0;
				end
			end
			OP_SWITCH: begin
				if (lvl_mask == '0) begin
					r.status = ST_NONE;
				end else begin
					lv = top_level();
					hd = turn[lv];
					turn[lv] = succ[hd];
					r.chosen_task = ID_W'(hd);
					r.chosen_valid = 1'b1;
				end
			end
			default: ;
		endcase
		r.any_ready = |lvl_mask;
		r.highest_ready = r.any_ready ? PRIO_W'(top_level()) : '0;
		return r;
	endfunction

	// Called just after a falling edge; returns just after the falling edge
	// that follows the transfer.
	task automatic send_item(input logic [OP_W-1:0] o, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= o;
		task_id      <= id;
		priority_req <= pr;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(sched_step(o, id, pr));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic test_empty_queue();
		send_item(OP_SWITCH, 5'd0, 5'd0);
		send_item(OP_REMOVE, 5'd0, 5'd0);
		send_item(OP_REMOVE, 5'd31, 5'd31);
		send_item(OP_W'(3), 5'd31, 5'd31);
	endtask

	task automatic test_rotation();
		send_item(OP_ADD, 5'd5, 5'd7);
		send_item(OP_ADD, 5'd9, 5'd7);
		send_item(OP_ADD, 5'd31, 5'd7);
		send_item(OP_ADD, 5'd9, 5'd7);
		repeat (4) send_item(OP_SWITCH, 5'd0, 5'd0);
		// turn is on task 9 now, removing it hands the turn to 31
		send_item(OP_REMOVE, 5'd9, 5'd0);
		send_item(OP_SWITCH, 5'd0, 5'd0);
	endtask

	task automatic test_levels();
		send_item(OP_ADD, 5'd0, 5'd31);
		send_item(OP_ADD, 5'd17, 5'd0);
		send_item(OP_SWITCH, 5'd31, 5'd31);
		send_item(OP_REMOVE, 5'd0, 5'd0);
		send_item(OP_REMOVE, 5'd0, 5'd0);
		send_item(OP_REMOVE, 5'd5, 5'd0);
		send_item(OP_REMOVE, 5'd31, 5'd0);
		send_item(OP_SWITCH, 5'd0, 5'd0);
		send_item(OP_REMOVE, 5'd17, 5'd0);
		send_item(OP_SWITCH, 5'd0, 5'd0);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		int target, nready, r, pick;
		logic [PRIO_W-1:0] lv;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = 1;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				target = $urandom_range(MAX_TASKS, 1);
			end
			if (i == count / 2) begin
				wait_drain();
			end
			nready = $countones(task_ready);
			r = $urandom_range(99);
			if (r < 8) begin
				send_item(OP_W'($urandom_range(3)), ID_W'($urandom), PRIO_W'($urandom));
			end else if (r < (nready < target ? 58 : 30) && nready < MAX_TASKS) begin
				do pick = $urandom_range(MAX_TASKS - 1); while (task_ready[TASK_W'(pick)]);
				// mostly a few shared levels so rotations get long
				case ($urandom_range(4))
					0: lv = 5'd0;
					1: lv = 5'd7;
					2: lv = 5'd19;
					3: lv = 5'd31;
					default: lv = PRIO_W'($urandom);
				endcase
				send_item(OP_ADD, ID_W'(pick), lv);
			end else if (r < 75 && nready > 0) begin
				do pick = $urandom_range(MAX_TASKS - 1); while (!task_ready[TASK_W'(pick)]);
				send_item(OP_REMOVE, ID_W'(pick), PRIO_W'($urandom));
			end else begin
				send_item(OP_SWITCH, ID_W'($urandom), PRIO_W'($urandom));
			end
		end
		wait_drain();
	endtask

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			err_count++;
		end
	endfunction

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 8'(want.status), 8'(status));
				check_field("chosen_task", 8'(want.chosen_task), 8'(chosen_task));
				check_field("chosen_valid", 8'(want.chosen_valid), 8'(chosen_valid));
				check_field("highest_ready", 8'(want.highest_ready), 8'(highest_ready));
				check_field("any_ready", 8'(want.any_ready), 8'(any_ready));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_queue();
		test_rotation();
		test_levels();
		wait_drain();
		test_random_traffic(185, 0, 0);
		test_random_traffic(185, 56, 0);
		test_random_traffic(185, 0, 56);
		test_random_traffic(185, 20, 20);
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
